// ----- rtl/dbq_pkg.sv -----
// Shared types and codes for the bounded double-ended queue.
package dbq_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned ITEM_W = 16;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_REMOVE     = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ITEM_W-1:0] item;
    } t_in_beat;

    typedef struct packed {
        logic [ITEM_W-1:0] item_out;
        logic              ok;
        logic [OCC_W-1:0]  occupancy;
    } t_out_beat;

endpackage

// ----- rtl/bounded_deque_with_removal.sv -----
// Top level of the bounded double-ended queue with removal by handle.
//
//  Channel  Direction  Handshake                  Beat
//  in       input      i_in_valid / o_in_ready    i_in_beat  (kind, item)
//  out      output     o_out_valid / i_out_ready  o_out_beat (item_out, ok, occupancy)
//
// One beat per cycle sustained while results are taken. A beat waits in the input
// register, is executed against the entry cells, and its result waits in the result
// register until the consumer takes it.
// Reset clears the fill count and both valid flags; entry cells hold no reset.
// A stalled result holds the input register; a beat is still taken if it is empty.
module bounded_deque_with_removal import dbq_pkg::*; #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ITEM_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic          r_in_valid;
    logic          n_in_valid;
    t_in_beat      r_in_beat;
    logic          w_advance;
    t_out_beat     w_result;
    logic [CW-1:0] w_count;

    // Execute the held beat when the result register can take its result
    assign w_advance  = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign n_in_valid = (i_in_valid && o_in_ready) || (r_in_valid && !w_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_beat;
        end
    end

    dbq_core #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (w_advance),
        .i_beat   (r_in_beat),
        .o_result (w_result),
        .o_count  (w_count)
    );

    dbq_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (o_out_beat)
    );

    // An executed beat always leaves a result behind
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("executed beat left no result");

    // A waiting result blocks execution
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_advance)
        else $error("beat executed over a stalled result");

    // Fill count moves only when a beat executes
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(w_count))
        else $error("fill count changed without a beat");

    // A successful insert grows the queue by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_result.ok &&
         (r_in_beat.kind == KIND_PUSH_BACK || r_in_beat.kind == KIND_PUSH_FRONT))
        |=> (w_count == $past(w_count) + CW'(1)))
        else $error("insert did not grow the queue");

    // A refused operation returns no handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_result.ok) |-> (w_result.item_out == '0))
        else $error("refused operation returned a handle");

endmodule

// ----- rtl/dbq_core.sv -----
// Entry cells, fill count and combinational operation logic of the queue.
module dbq_core import dbq_pkg::*; #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned ITEM_WIDTH = 16,
    localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_exec,
    input  t_in_beat        i_beat,
    output t_out_beat       o_result,
    output logic [CW-1:0]   o_count
);

    logic [ITEM_WIDTH-1:0]        r_entry [DEPTH];
    logic [ITEM_WIDTH-1:0]        n_entry [DEPTH];
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [ITEM_WIDTH+ITEM_W-1:0] w_in_ext;
    logic [ITEM_WIDTH+ITEM_W-1:0] w_out_ext;
    logic [CW+OCC_W-1:0]          w_occ_ext;
    logic [ITEM_WIDTH-1:0]        w_handle;
    logic [ITEM_WIDTH-1:0]        w_taken;
    logic [DEPTH-1:0]             w_match;
    logic [DEPTH-1:0]             w_pre;
    logic [DEPTH-1:0]             w_first;
    logic [DEPTH-1:0]             w_last;
    logic [DEPTH-1:0]             w_sel;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_ok;
    t_kind                        w_kind;

    // Fit the incoming handle to the stored width
    assign w_in_ext = {{ITEM_WIDTH{1'b0}}, i_beat.item};
    assign w_handle = w_in_ext[ITEM_WIDTH-1:0];
    assign w_kind   = t_kind'(i_beat.kind);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    // Per-cell match, gap marker and next value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);
        localparam logic [CW-1:0] NXT = CW'(g + 1);
        logic [ITEM_WIDTH-1:0] w_up;
        logic [ITEM_WIDTH-1:0] w_down;

        assign w_match[g] = (IDX < r_count) && (r_entry[g] == w_handle);
        assign w_pre[g]   = |w_match[g:0];
        assign w_last[g]  = (NXT == r_count);

        if (g == 0) begin : g_head
            assign w_first[g] = w_match[g];
            assign w_down     = w_handle;
        end else begin : g_body
            assign w_first[g] = w_match[g] & ~w_pre[g-1];
            assign w_down     = r_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_up = r_entry[g];
        end else begin : g_inner
            assign w_up = r_entry[g+1];
        end

        always_comb begin
            n_entry[g] = r_entry[g];
            case (w_kind)
                KIND_PUSH_BACK: begin
                    if (!w_full && (IDX == r_count)) n_entry[g] = w_handle;
                end
                KIND_PUSH_FRONT: begin
                    if (!w_full) n_entry[g] = w_down;
                end
                KIND_POP_FRONT: begin
                    if (!w_empty) n_entry[g] = w_up;
                end
                KIND_REMOVE: begin
                    // close the gap behind the first match
                    if (w_pre[g]) n_entry[g] = w_up;
                end
                KIND_POP_BACK: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Decide outcome, new count and which cell is taken out
    always_comb begin
        n_count = r_count;
        w_ok    = 1'b0;
        w_sel   = '0;
        case (w_kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (!w_full) begin
                    w_ok    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            KIND_POP_BACK: begin
                if (!w_empty) begin
                    w_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                    w_sel   = w_last;
                end
            end
            KIND_POP_FRONT: begin
                if (!w_empty) begin
                    w_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                    w_sel   = DEPTH'(1);
                end
            end
            KIND_REMOVE: begin
                if (w_pre[DEPTH-1]) begin
                    w_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                    w_sel   = w_first;
                end
            end
            default: begin
            end
        endcase
    end

    // Gather the removed handle from the one selected cell
    always_comb begin
        w_taken = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_taken = w_taken | (w_sel[i] ? r_entry[i] : '0);
        end
    end

    // Shape the result beat
    assign w_out_ext          = {{ITEM_W{1'b0}}, w_taken};
    assign w_occ_ext          = {{OCC_W{1'b0}}, n_count};
    assign o_result.item_out  = w_out_ext[ITEM_W-1:0];
    assign o_result.ok        = w_ok;
    assign o_result.occupancy = w_occ_ext[OCC_W-1:0];
    assign o_count            = r_count;

    // Advance fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_exec) begin
            r_count <= n_count;
        end
    end

    // Update entry cells
    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

endmodule

// ----- rtl/dbq_out_reg.sv -----
// Result register that holds a beat until the consumer takes it.
module dbq_out_reg import dbq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_beat i_result,
    input  logic      i_ready,
    output logic      o_valid,
    output t_out_beat o_result
);

    logic      r_valid;
    logic      n_valid;
    t_out_beat r_result;

    // Fill on load, drop once taken
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
